@@ sv/sexp_pkg.sv @@
`default_nettype none

package sexp_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int VAR_ID_BITS_DEF = 16;

  localparam int DATA_W    = 32;
  localparam int ID_PORT_W = 16;

  // token commands
  localparam logic [1:0] CMD_LIT = 2'd0;
  localparam logic [1:0] CMD_VAR = 2'd1;
  localparam logic [1:0] CMD_OP  = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  // operator codes
  localparam logic [4:0] OP_END    = 5'h00;
  localparam logic [4:0] OP_NEG    = 5'h01;
  localparam logic [4:0] OP_ZERO   = 5'h02;
  localparam logic [4:0] OP_NOT    = 5'h03;
  localparam logic [4:0] OP_ADD    = 5'h04;
  localparam logic [4:0] OP_SUB    = 5'h05;
  localparam logic [4:0] OP_MUL    = 5'h06;
  localparam logic [4:0] OP_DIV    = 5'h07;
  localparam logic [4:0] OP_REM    = 5'h08;
  localparam logic [4:0] OP_SHL    = 5'h09;
  localparam logic [4:0] OP_SHR    = 5'h0A;
  localparam logic [4:0] OP_EQ     = 5'h0B;
  localparam logic [4:0] OP_NE     = 5'h0C;
  localparam logic [4:0] OP_LT     = 5'h0D;
  localparam logic [4:0] OP_LE     = 5'h0E;
  localparam logic [4:0] OP_GT     = 5'h0F;
  localparam logic [4:0] OP_GE     = 5'h10;
  localparam logic [4:0] OP_OR     = 5'h11;
  localparam logic [4:0] OP_AND    = 5'h12;
  localparam logic [4:0] OP_XOR    = 5'h13;
  localparam logic [4:0] OP_LOR    = 5'h14;
  localparam logic [4:0] OP_LAND   = 5'h15;
  localparam logic [4:0] OP_ASSIGN = 5'h16;

  // result kinds
  localparam logic [1:0] KIND_FINAL = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_OVF    = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_DIVZ   = 3'd3;
  localparam logic [2:0] ERR_ASSIGN = 3'd4;

  // local argument slots keep only the low nibble of the handle
  localparam logic [ID_PORT_W-1:0] LOCAL_ID_MASK = 16'h000F;

  typedef struct packed {
    logic load;
    logic div_start;
    logic commit;
  } sexp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic has_out;
    logic out_free;
    logic div_done;
  } sexp_stat_t;

endpackage

`default_nettype wire

@@ sv/sexp_div.sv @@
`default_nettype none

module sexp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sexp_pkg::DATA_W-1:0] dividend,
  input  logic [sexp_pkg::DATA_W-1:0] divisor,
  output logic                        done,
  output logic [sexp_pkg::DATA_W-1:0] quotient,
  output logic [sexp_pkg::DATA_W-1:0] remainder
);

  localparam int DW   = sexp_pkg::DATA_W;
  localparam int CntW = $clog2(DW);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DW-1:0]   num;
  logic [DW-1:0]   den;
  logic [DW-1:0]   rem;
  logic            neg_q;
  logic            neg_r;

  logic [DW-1:0]   dvd_mag;
  logic [DW-1:0]   dvs_mag;
  logic [DW:0]     shifted;
  logic [DW:0]     trial;
  logic            q_bit;
  logic [DW-1:0]   rem_next;

  assign dvd_mag = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
  assign dvs_mag = divisor[DW-1] ? (~divisor + DW'(1)) : divisor;

  // restoring step, one quotient bit per cycle
  assign shifted  = {rem, num[DW-1]};
  assign trial    = shifted - {1'b0, den};
  assign q_bit    = ~trial[DW];
  assign rem_next = q_bit ? trial[DW-1:0] : shifted[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DW - 1);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num   <= dvd_mag;
      den   <= dvs_mag;
      rem   <= '0;
      neg_q <= dividend[DW-1] ^ divisor[DW-1];
      neg_r <= dividend[DW-1];
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[DW-2:0], q_bit};
    end
  end

  // quotient truncates toward zero, remainder takes the dividend's sign
  assign quotient  = neg_q ? (~num + DW'(1)) : num;
  assign remainder = neg_r ? (~rem + DW'(1)) : rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy) && !$past(start))
    else $error("divider done without a finished run");

endmodule

`default_nettype wire

@@ sv/sexp_dp.sv @@
`default_nettype none

module sexp_dp #(
  parameter int STACK_DEPTH = sexp_pkg::STACK_DEPTH_DEF,
  parameter int VAR_ID_BITS = sexp_pkg::VAR_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sexp_pkg::sexp_cmd_t            ctl,
  output sexp_pkg::sexp_stat_t           stat,
  input  logic [1:0]                     cmd,
  input  logic [sexp_pkg::DATA_W-1:0]    value,
  input  logic                           var_kind,
  input  logic [sexp_pkg::ID_PORT_W-1:0] var_id,
  input  logic [4:0]                     opcode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [sexp_pkg::DATA_W-1:0]    result_value,
  output logic                           write_kind,
  output logic [sexp_pkg::ID_PORT_W-1:0] write_id,
  output logic [2:0]                     error_code
);

  localparam int DW   = sexp_pkg::DATA_W;
  localparam int IW   = sexp_pkg::ID_PORT_W;
  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int SpW  = $clog2(STACK_DEPTH + 1);
  localparam int RefW = VAR_ID_BITS + 2;  // {valid, kind, id}

  // latched token
  logic [1:0]             it_cmd;
  logic [DW-1:0]          it_value;
  logic                   it_kind;
  logic [VAR_ID_BITS-1:0] it_id;
  logic [4:0]             it_op;

  logic [31:0]            var_id_ext;

  // stack
  logic [DW-1:0]   val_mem [STACK_DEPTH];
  logic [RefW-1:0] ref_mem [STACK_DEPTH];
  logic [SpW-1:0]  sp;
  logic [SpW-1:0]  sp_next;
  logic [SpW-1:0]  sp_m1;
  logic [SpW-1:0]  sp_m2;
  logic [IdxW-1:0] top_idx;
  logic [IdxW-1:0] sec_idx;
  logic [IdxW-1:0] push_idx;

  logic [DW-1:0]   r_val;
  logic [DW-1:0]   l_val;
  logic [RefW-1:0] l_ref;

  logic            val_we;
  logic            ref_we;
  logic [IdxW-1:0] wr_idx;
  logic [DW-1:0]   wr_val;
  logic [RefW-1:0] wr_ref;

  logic [DW-1:0]   alu_res;
  logic [DW-1:0]   div_q;
  logic [DW-1:0]   div_r;
  logic            div_done;

  logic            has_out;
  logic [1:0]      res_kind;
  logic [DW-1:0]   res_value;
  logic            res_wk;
  logic [IW-1:0]   res_wid;
  logic [2:0]      res_err;
  logic            need_div;

  logic [31:0]     lref_id_ext;
  logic [IW-1:0]   lref_id;
  logic            out_free;

  assign var_id_ext = 32'(var_id);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it_cmd   <= cmd;
      it_value <= value;
      it_kind  <= var_kind;
      it_id    <= var_id_ext[VAR_ID_BITS-1:0];
      it_op    <= opcode;
    end
  end

  assign sp_m1    = sp - SpW'(1);
  assign sp_m2    = sp - SpW'(2);
  assign top_idx  = sp_m1[IdxW-1:0];
  assign sec_idx  = sp_m2[IdxW-1:0];
  assign push_idx = sp[IdxW-1:0];

  // top two entries are read every cycle; sp is stable while a token is at work
  always_ff @(posedge clk) begin
    r_val <= val_mem[top_idx];
    l_val <= val_mem[sec_idx];
    l_ref <= ref_mem[sec_idx];
    if (ctl.commit && val_we) begin
      val_mem[wr_idx] <= wr_val;
    end
    if (ctl.commit && ref_we) begin
      ref_mem[wr_idx] <= wr_ref;
    end
  end

  sexp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (l_val),
    .divisor   (r_val),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    case (it_op) inside
      sexp_pkg::OP_NEG:                   alu_res = DW'(0) - r_val;
      sexp_pkg::OP_ZERO, sexp_pkg::OP_NOT: alu_res = DW'(r_val == '0);
      sexp_pkg::OP_ADD:                   alu_res = l_val + r_val;
      sexp_pkg::OP_SUB:                   alu_res = l_val - r_val;
      sexp_pkg::OP_MUL:                   alu_res = l_val * r_val;
      sexp_pkg::OP_DIV:                   alu_res = div_q;
      sexp_pkg::OP_REM:                   alu_res = div_r;
      sexp_pkg::OP_SHL:                   alu_res = l_val << r_val[4:0];
      sexp_pkg::OP_SHR:                   alu_res = $signed(l_val) >>> r_val[4:0];
      sexp_pkg::OP_EQ:                    alu_res = DW'(l_val == r_val);
      sexp_pkg::OP_NE:                    alu_res = DW'(l_val != r_val);
      sexp_pkg::OP_LT:                    alu_res = DW'($signed(l_val) < $signed(r_val));
      sexp_pkg::OP_LE:                    alu_res = DW'($signed(l_val) <= $signed(r_val));
      sexp_pkg::OP_GT:                    alu_res = DW'($signed(l_val) > $signed(r_val));
      sexp_pkg::OP_GE:                    alu_res = DW'($signed(l_val) >= $signed(r_val));
      sexp_pkg::OP_OR:                    alu_res = l_val | r_val;
      sexp_pkg::OP_AND:                   alu_res = l_val & r_val;
      sexp_pkg::OP_XOR:                   alu_res = l_val ^ r_val;
      sexp_pkg::OP_LOR:                   alu_res = DW'((l_val | r_val) != '0);
      sexp_pkg::OP_LAND:                  alu_res = DW'((l_val != '0) && (r_val != '0));
      default:                            alu_res = '0;
    endcase
  end

  assign lref_id_ext = 32'(l_ref[VAR_ID_BITS-1:0]);
  assign lref_id     = lref_id_ext[IW-1:0];

  always_comb begin
    sp_next   = sp;
    val_we    = 1'b0;
    ref_we    = 1'b0;
    wr_idx    = push_idx;
    wr_val    = it_value;
    wr_ref    = '0;
    has_out   = 1'b0;
    res_kind  = sexp_pkg::KIND_ERROR;
    res_value = '0;
    res_wk    = 1'b0;
    res_wid   = '0;
    res_err   = sexp_pkg::ERR_NONE;
    need_div  = 1'b0;
    case (it_cmd) inside
      sexp_pkg::CMD_LIT, sexp_pkg::CMD_VAR: begin
        if (sp == SpW'(STACK_DEPTH)) begin
          has_out = 1'b1;
          res_err = sexp_pkg::ERR_OVF;
          sp_next = '0;
        end else begin
          val_we  = 1'b1;
          ref_we  = 1'b1;
          wr_ref  = (it_cmd == sexp_pkg::CMD_VAR) ? {1'b1, it_kind, it_id} : '0;
          sp_next = sp + SpW'(1);
        end
      end
      sexp_pkg::CMD_OP: begin
        if (it_op == sexp_pkg::OP_END) begin
          has_out = 1'b1;
          sp_next = '0;
          if (sp == '0) begin
            res_err = sexp_pkg::ERR_UNDER;
          end else begin
            res_kind  = sexp_pkg::KIND_FINAL;
            res_value = r_val;
          end
        end else if (sp < SpW'(2)) begin
          has_out = 1'b1;
          res_err = sexp_pkg::ERR_UNDER;
          sp_next = '0;
        end else if (it_op == sexp_pkg::OP_ASSIGN) begin
          has_out = 1'b1;
          if (!l_ref[RefW-1]) begin
            res_err = sexp_pkg::ERR_ASSIGN;
            sp_next = '0;
          end else begin
            // value lands on the left entry, which keeps its reference
            res_kind  = sexp_pkg::KIND_WRITE;
            res_value = r_val;
            res_wk    = l_ref[RefW-2];
            res_wid   = l_ref[RefW-2] ? (lref_id & sexp_pkg::LOCAL_ID_MASK) : lref_id;
            val_we    = 1'b1;
            wr_idx    = sec_idx;
            wr_val    = r_val;
            sp_next   = sp_m1;
          end
        end else if ((it_op == sexp_pkg::OP_DIV || it_op == sexp_pkg::OP_REM) &&
                     r_val == '0) begin
          has_out = 1'b1;
          res_err = sexp_pkg::ERR_DIVZ;
          sp_next = '0;
        end else begin
          need_div = (it_op == sexp_pkg::OP_DIV || it_op == sexp_pkg::OP_REM);
          val_we   = 1'b1;
          ref_we   = 1'b1;
          wr_idx   = sec_idx;
          wr_val   = alu_res;
          sp_next  = sp_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.commit) begin
      sp <= sp_next;
    end
  end

  // output word register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit && has_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit && has_out) begin
      kind         <= res_kind;
      result_value <= res_value;
      write_kind   <= res_wk;
      write_id     <= res_wid;
      error_code   <= res_err;
    end
  end

  assign stat.need_div = need_div;
  assign stat.has_out  = has_out;
  assign stat.out_free = out_free;
  assign stat.div_done = div_done;

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SpW'(STACK_DEPTH))
    else $error("stack pointer past depth");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sexp_pkg::KIND_ERROR |->
      result_value == '0 && write_id == '0 && error_code != sexp_pkg::ERR_NONE)
    else $error("malformed error word");

  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && has_out && res_kind == sexp_pkg::KIND_ERROR |=> sp == '0)
    else $error("stack not emptied after error");

endmodule

`default_nettype wire

@@ sv/sexp_ctrl.sv @@
`default_nettype none

module sexp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sexp_pkg::sexp_stat_t stat,
  output sexp_pkg::sexp_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    ctl.load      = 1'b0;
    ctl.div_start = 1'b0;
    ctl.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_div) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
        end else if (!stat.has_out || stat.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        // divide never produces a word, so no wait on the output here
        if (stat.div_done) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

@@ sv/stack_expression_evaluator.sv @@
// Postfix expression evaluator over an on-chip stack of STACK_DEPTH entries,
// each a 32-bit value plus a variable reference. One token word is taken at a
// time: the top two entries are read at the accepting edge, the execute state
// computes and writes back, and the block is then free for the next word;
// divide and remainder add the 32 steps of the one-bit-per-cycle restoring
// divider and a wait on its done flag. A token whose result word finds the
// output register still full waits there until it drains. Final values,
// variable writes and errors leave through a single output register; any
// error empties the stack.
`default_nettype none

module stack_expression_evaluator #(
  parameter int STACK_DEPTH = sexp_pkg::STACK_DEPTH_DEF,
  parameter int VAR_ID_BITS = sexp_pkg::VAR_ID_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [sexp_pkg::DATA_W-1:0]    value,
  input  logic                           var_kind,
  input  logic [sexp_pkg::ID_PORT_W-1:0] var_id,
  input  logic [4:0]                     opcode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     kind,
  output logic [sexp_pkg::DATA_W-1:0]    result_value,
  output logic                           write_kind,
  output logic [sexp_pkg::ID_PORT_W-1:0] write_id,
  output logic [2:0]                     error_code
);

  sexp_pkg::sexp_cmd_t  ctl;
  sexp_pkg::sexp_stat_t stat;

  sexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  sexp_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_ID_BITS (VAR_ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .cmd          (cmd),
    .value        (value),
    .var_kind     (var_kind),
    .var_id       (var_id),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .result_value (result_value),
    .write_kind   (write_kind),
    .write_id     (write_id),
    .error_code   (error_code)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_stack_expression_evaluator.sv @@
`default_nettype none

module tb_stack_expression_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] val;
    logic        wkind;
    logic [15:0] wid;
    logic [2:0]  err;
  } eval_word_t;

  // Mirrors the evaluator stack and holds the words it should emit, oldest first.
  class eval_scoreboard;
    logic [31:0] vals[8];
    logic        ref_ok[8];
    logic        ref_local[8];
    logic [15:0] ref_id[8];
    int          depth;
    eval_word_t  due[$];
    int          bad;

    function new();
      depth = 0;
      bad = 0;
    endfunction

    function void push_due(logic [1:0] k, logic [31:0] v, logic wk, logic [15:0] wid,
                           logic [2:0] err);
      eval_word_t w;
      w.kind = k;
      w.val = v;
      w.wkind = wk;
      w.wid = wid;
      w.err = err;
      due.push_back(w);
    endfunction

    function void raise_error(logic [2:0] err);
      depth = 0;
      push_due(sexp_pkg::KIND_ERROR, '0, 1'b0, '0, err);
    endfunction

    function void note_token(logic [1:0] c, logic [31:0] v, logic k, logic [15:0] id,
                             logic [4:0] op);
      logic [31:0] r;
      logic [31:0] l;
      logic [31:0] res;
      longint      sl;
      longint      sr;
      logic [15:0] wid;
      if (c == sexp_pkg::CMD_NOP) return;
      if (c != sexp_pkg::CMD_OP) begin
        if (depth >= 8) begin
          raise_error(sexp_pkg::ERR_OVF);
          return;
        end
        vals[depth] = v;
        ref_ok[depth] = (c == sexp_pkg::CMD_VAR);
        ref_local[depth] = k;
        ref_id[depth] = id;
        depth++;
        return;
      end
      if (op == sexp_pkg::OP_END) begin
        if (depth == 0) raise_error(sexp_pkg::ERR_UNDER);
        else begin
          push_due(sexp_pkg::KIND_FINAL, vals[depth-1], 1'b0, '0, sexp_pkg::ERR_NONE);
          depth = 0;
        end
        return;
      end
      if (depth < 2) begin
        raise_error(sexp_pkg::ERR_UNDER);
        return;
      end
      r = vals[depth-1];
      l = vals[depth-2];
      sl = longint'($signed(l));
      sr = longint'($signed(r));
      if (op == sexp_pkg::OP_ASSIGN) begin
        if (!ref_ok[depth-2]) raise_error(sexp_pkg::ERR_ASSIGN);
        else begin
          wid = ref_local[depth-2] ? (ref_id[depth-2] & sexp_pkg::LOCAL_ID_MASK)
                                   : ref_id[depth-2];
          push_due(sexp_pkg::KIND_WRITE, r, ref_local[depth-2], wid, sexp_pkg::ERR_NONE);
          depth--;
          // value replaced, reference of the left entry kept
          vals[depth-1] = r;
        end
        return;
      end
      if ((op == sexp_pkg::OP_DIV || op == sexp_pkg::OP_REM) && r == 0) begin
        raise_error(sexp_pkg::ERR_DIVZ);
        return;
      end
      case (op)
        sexp_pkg::OP_NEG:  res = -r;
        sexp_pkg::OP_ZERO: res = 32'(r == 0);
        sexp_pkg::OP_NOT:  res = 32'(r == 0);
        sexp_pkg::OP_ADD:  res = l + r;
        sexp_pkg::OP_SUB:  res = l - r;
        sexp_pkg::OP_MUL:  res = l * r;
        sexp_pkg::OP_DIV:  res = 32'(sl / sr);
        sexp_pkg::OP_REM:  res = 32'(sl % sr);
        sexp_pkg::OP_SHL:  res = l << r[4:0];
        sexp_pkg::OP_SHR:  res = $signed(l) >>> r[4:0];
        sexp_pkg::OP_EQ:   res = 32'(l == r);
        sexp_pkg::OP_NE:   res = 32'(l != r);
        sexp_pkg::OP_LT:   res = 32'(sl < sr);
        sexp_pkg::OP_LE:   res = 32'(sl <= sr);
        sexp_pkg::OP_GT:   res = 32'(sl > sr);
        sexp_pkg::OP_GE:   res = 32'(sl >= sr);
        sexp_pkg::OP_OR:   res = l | r;
        sexp_pkg::OP_AND:  res = l & r;
        sexp_pkg::OP_XOR:  res = l ^ r;
        sexp_pkg::OP_LOR:  res = 32'((l | r) != 0);
        sexp_pkg::OP_LAND: res = 32'(l != 0 && r != 0);
        default:           res = '0;
      endcase
      depth--;
      vals[depth-1] = res;
      ref_ok[depth-1] = 1'b0;
    endfunction

    function void report(string what, eval_word_t exp_w, eval_word_t got_w);
      bad++;
      if (bad <= 10) begin
        $write("%0t: %s exp kind=%0d val=%h wk=%0d wid=%h err=%0d",
               $realtime, what, exp_w.kind, exp_w.val, exp_w.wkind, exp_w.wid, exp_w.err);
        $display(" got kind=%0d val=%h wk=%0d wid=%h err=%0d",
                 got_w.kind, got_w.val, got_w.wkind, got_w.wid, got_w.err);
      end
    endfunction

    function void check_word(eval_word_t got_w);
      eval_word_t exp_w;
      if (due.size() == 0) begin
        report("unexpected word", '0, got_w);
        return;
      end
      exp_w = due.pop_front();
      if (got_w.kind !== exp_w.kind || got_w.val !== exp_w.val ||
          got_w.wkind !== exp_w.wkind || got_w.wid !== exp_w.wid ||
          got_w.err !== exp_w.err)
        report("mismatch", exp_w, got_w);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = sexp_pkg::CMD_NOP;
  logic [31:0] value = '0;
  logic        var_kind = 1'b0;
  logic [15:0] var_id = '0;
  logic [4:0]  opcode = sexp_pkg::OP_END;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] result_value;
  logic        write_kind;
  logic [15:0] write_id;
  logic [2:0]  error_code;

  eval_scoreboard sb = new();
  int  sent = 0;
  bit  quiet = 1'b0;
  bit  in_idle_on = 1'b1;
  bit  out_idle_on = 1'b1;
  int  stall_left = 0;

  stack_expression_evaluator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .value(value), .var_kind(var_kind), .var_id(var_id), .opcode(opcode),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .result_value(result_value), .write_kind(write_kind),
    .write_id(write_id), .error_code(error_code)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (quiet || rst || !out_idle_on) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 11) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_word({kind, result_value, write_kind, write_id, error_code});
  end

  // entered at a falling edge, returns at the falling edge after the word is taken
  task automatic send_token(logic [1:0] c, logic [31:0] v, logic k, logic [15:0] id,
                            logic [4:0] op);
    if (in_idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd = c;
    value = v;
    var_kind = k;
    var_id = id;
    opcode = op;
    do @(posedge clk); while (in_stall);
    sb.note_token(c, v, k, id, op);
    if (c != sexp_pkg::CMD_NOP) sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3, 4, 5: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_operand();
    if ($urandom_range(0, 2) == 0)
      send_token(sexp_pkg::CMD_VAR, pick_value(), 1'($urandom_range(0, 1)), 16'($urandom),
                 5'($urandom_range(0, 31)));
    else
      send_token(sexp_pkg::CMD_LIT, pick_value(), 1'($urandom_range(0, 1)), 16'($urandom),
                 5'($urandom_range(0, 31)));
  endtask

  task automatic run_expression();
    int ops;
    int mode;
    logic [4:0] op;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // noise: any command, any opcode
      repeat ($urandom_range(1, 10))
        send_token(2'($urandom_range(0, 3)), pick_value(), 1'($urandom_range(0, 1)),
                   16'($urandom), 5'($urandom_range(0, 31)));
    end else if (mode == 1) begin
      // long push runs, often past the stack top
      repeat ($urandom_range(6, 10)) push_operand();
      if ($urandom_range(0, 1)) send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_END);
    end else begin
      ops = $urandom_range(1, 6);
      while (ops > 0) begin
        if (sb.depth < 2) push_operand();
        else if (sb.depth >= 7 || $urandom_range(0, 1)) begin
          if (sb.ref_ok[sb.depth-2] && $urandom_range(0, 2) == 0) op = sexp_pkg::OP_ASSIGN;
          else if ($urandom_range(0, 11) == 0) op = 5'($urandom_range(23, 31));
          else op = 5'($urandom_range(1, 22));
          send_token(sexp_pkg::CMD_OP, $urandom, 1'($urandom_range(0, 1)), 16'($urandom), op);
          ops--;
        end else push_operand();
      end
      if ($urandom_range(0, 9) != 0)
        send_token(sexp_pkg::CMD_OP, $urandom, 1'b0, 16'($urandom), sexp_pkg::OP_END);
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // end on an empty stack, unary operator with a single entry
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_LIT, 32'd1, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_NEG);
    // most negative over -1 wraps, its remainder is zero
    send_token(sexp_pkg::CMD_LIT, 32'h8000_0000, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_LIT, 32'hFFFF_FFFF, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_DIV);
    send_token(sexp_pkg::CMD_LIT, 32'hFFFF_FFFF, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_REM);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_END);
    // remainder by zero
    send_token(sexp_pkg::CMD_LIT, 32'd5, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_LIT, 32'd0, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_REM);
    // assign to a literal
    send_token(sexp_pkg::CMD_LIT, 32'd3, 1'b1, 16'hFFFF, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_LIT, 32'd4, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_ASSIGN);
    // assign to a local slot, then an unused opcode
    send_token(sexp_pkg::CMD_VAR, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_LIT, 32'h8000_0000, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_ASSIGN);
    send_token(sexp_pkg::CMD_LIT, 32'h7FFF_FFFF, 1'b0, '0, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, 5'h1F);
    send_token(sexp_pkg::CMD_OP, '0, 1'b0, '0, sexp_pkg::OP_END);
    // fill the stack, an ignored word, then one push too many
    repeat (8) send_token(sexp_pkg::CMD_VAR, $urandom, 1'b0, 16'hFFFF, sexp_pkg::OP_END);
    send_token(sexp_pkg::CMD_NOP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 5'h1F);
    send_token(sexp_pkg::CMD_LIT, 32'd9, 1'b0, '0, sexp_pkg::OP_END);

    while (sent < 550) begin
      if (sent >= 450) quiet = 1'b1;
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      run_expression();
    end
    in_valid = 1'b0;

    waited = 0;
    while (sb.due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    if (sb.bad == 0 && sb.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/sexp_pkg.sv
sv/sexp_div.sv
sv/sexp_dp.sv
sv/sexp_ctrl.sv
sv/stack_expression_evaluator.sv
tb/sv/tb_stack_expression_evaluator.sv
